// File: hw/rtl/vfsa_pkg.sv
// ----------------------------------------------------------------------------
// vfsa_pkg: shared types and constants for the value histogram block
// Field widths, result codes and the records passed between the front end,
// the item queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package vfsa_pkg;

  // Field widths fixed by the stream format
  localparam int VALUE_W = 5;
  localparam int COUNT_W = 8;
  localparam int SUM_W   = 12;
  localparam int MEAN_W  = 5;

  // Saturation limit of the running sum
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Result kinds carried in tuser
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Classified item as queued by the front end; the batch totals ride along
  // so the back end has them on the marked item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               count_it;
    logic               last;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] total;
    logic               drop;
  } vfsa_item_t;

  // One result as produced by the back end
  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] occurrences;
    logic [SUM_W-1:0]   total_sum;
    logic [MEAN_W-1:0]  mean_rounded;
    logic               overflowed;
    logic               last_result;
  } vfsa_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/vfsa_fifo.sv
// ----------------------------------------------------------------------------
// vfsa_fifo: short item queue
// Four-entry first-in first-out buffer of classified items with show-ahead
// read data, decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vfsa_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vfsa_pkg::vfsa_item_t push_item,
  output logic                full,
  input  logic                pop,
  output vfsa_pkg::vfsa_item_t pop_item,
  output logic                empty
);
  import vfsa_pkg::*;

  vfsa_item_t          store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full     = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_item = store[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push && !full) begin
      store[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vfsa_front.sv
// ----------------------------------------------------------------------------
// vfsa_front: input classification and batch totals
// Accepts one value per transfer, sorts it into counted, dropped or ignored,
// keeps item count, saturating sum and drop flag, and queues the item.
// ----------------------------------------------------------------------------
`default_nettype none

module vfsa_front #(
  parameter int BINS      = 32,
  parameter int MAX_ITEMS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vfsa_pkg::VALUE_W-1:0]  in_value,
  input  logic                          in_last,
  output logic                          push,
  output vfsa_pkg::vfsa_item_t           push_item,
  input  logic                          queue_full
);
  import vfsa_pkg::*;

  logic [COUNT_W-1:0] item_total;
  logic [SUM_W-1:0]   running_sum;
  logic               drop_flag;

  logic               take;
  logic               in_range;
  logic               at_limit;
  logic               count_it;
  logic [SUM_W:0]     sum_wide;
  logic [COUNT_W-1:0] item_total_next;
  logic [SUM_W-1:0]   running_sum_next;
  logic               drop_flag_next;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  // Classify the incoming value
  assign in_range = ({1'b0, in_value} < (VALUE_W+1)'(BINS));
  assign at_limit = (item_total >= COUNT_W'(MAX_ITEMS));
  assign count_it = in_range && !at_limit;

  // Update the batch totals
  assign sum_wide         = {1'b0, running_sum} + (SUM_W+1)'(in_value);
  assign running_sum_next = !count_it     ? running_sum :
                            sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign item_total_next  = count_it ? item_total + 1'b1 : item_total;
  assign drop_flag_next   = drop_flag || (in_range && at_limit);

  // Queue the classified item with the totals after it
  assign push                = take;
  assign push_item.value     = in_value;
  assign push_item.count_it  = count_it;
  assign push_item.last      = in_last;
  assign push_item.sum       = running_sum_next;
  assign push_item.total     = item_total_next;
  assign push_item.drop      = drop_flag_next;

  // Hold totals; clear them once the marked item is queued
  always_ff @(posedge clk) begin
    if (rst) begin
      item_total  <= '0;
      running_sum <= '0;
      drop_flag   <= 1'b0;
    end else if (take) begin
      if (in_last) begin
        item_total  <= '0;
        running_sum <= '0;
        drop_flag   <= 1'b0;
      end else begin
        item_total  <= item_total_next;
        running_sum <= running_sum_next;
        drop_flag   <= drop_flag_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vfsa_div.sv
// ----------------------------------------------------------------------------
// vfsa_div: rounded mean divider
// Restoring division of the sum by the item count, one quotient bit a cycle,
// then round to nearest with ties to even. A zero count gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vfsa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vfsa_pkg::SUM_W-1:0]    dividend,
  input  logic [vfsa_pkg::COUNT_W-1:0]  divisor,
  output logic                          done,
  output logic [vfsa_pkg::MEAN_W-1:0]   mean
);
  import vfsa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [SUM_W-1:0]   quo;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic               zero_div;

  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [COUNT_W:0]   diff;
  logic [COUNT_W:0]   twice_rem;
  logic               round_up;
  logic [SUM_W-1:0]   quo_rounded;

  // One restoring step
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  // Round to nearest, ties to even
  assign twice_rem   = {rem, 1'b0};
  assign round_up    = (twice_rem > {1'b0, dvs}) || ((twice_rem == {1'b0, dvs}) && quo[0]);
  assign quo_rounded = quo + SUM_W'(round_up);
  assign mean        = zero_div ? '0 : quo_rounded[MEAN_W-1:0];

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step     <= '0;
      zero_div <= 1'b0;
    end else if (start) begin
      zero_div <= (divisor == '0);
      busy     <= (divisor != '0);
      done     <= (divisor == '0);
      step     <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(SUM_W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient and remainder datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vfsa_back.sv
// ----------------------------------------------------------------------------
// vfsa_back: histogram store and result sequencer
// Updates the bin counts and first-seen order from queued items, then on the
// marked item walks the order list, emits entries and the summary, clears.
// ----------------------------------------------------------------------------
`default_nettype none

module vfsa_back #(
  parameter int BINS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   queue_empty,
  input  vfsa_pkg::vfsa_item_t    queue_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vfsa_pkg::vfsa_result_t  out_result
);
  import vfsa_pkg::*;

  // Values above 31 cannot arrive, so the store is never deeper than 32
  localparam int CNT_D  = (BINS < (1 << VALUE_W)) ? BINS : (1 << VALUE_W);
  localparam int CNT_AW = $clog2(CNT_D);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_ENT  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;

  logic [2:0]         state;

  // Update stage holding the item whose count is being read
  logic               b_valid;
  vfsa_item_t         b_item;

  // Count memory with per-entry valid bits
  logic [COUNT_W-1:0] cnt_mem [CNT_D];
  logic [CNT_D-1:0]   cnt_vld;
  logic               cnt_re;
  logic [CNT_AW-1:0]  cnt_ra;
  logic [COUNT_W-1:0] cnt_rd;
  logic               cnt_we;
  logic [CNT_AW-1:0]  cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;

  // First-seen order memory
  logic [VALUE_W-1:0] ord_mem [CNT_D];
  logic               ord_we;
  logic               ord_re;
  logic [VALUE_W-1:0] ord_rd;

  logic [CNT_AW:0]    distinct_total;
  logic [CNT_AW:0]    walk;
  logic [SUM_W-1:0]   sum_hold;
  logic               drop_hold;

  logic               out_free;
  logic               load_ent;
  logic               load_sum;
  logic               div_start;
  logic               div_done;
  logic [MEAN_W-1:0]  div_mean;

  // Pop one item a cycle while loading; stop behind the marked item
  assign pop = (state == S_LOAD) && !queue_empty && !(b_valid && b_item.last);

  assign cnt_re = pop || (state == S_CNT);
  assign cnt_ra = (state == S_CNT) ? ord_rd[CNT_AW-1:0] : queue_item.value[CNT_AW-1:0];
  assign cnt_we = b_valid && b_item.count_it;
  assign cnt_wa = b_item.value[CNT_AW-1:0];
  assign cnt_wd = cnt_rd + 1'b1;
  assign ord_we = cnt_we && (cnt_rd == '0);
  assign ord_re = (state == S_NEXT) && (walk < distinct_total);

  assign out_free  = !out_valid || out_ready;
  assign load_ent  = (state == S_ENT) && out_free;
  assign load_sum  = (state == S_SUM) && div_done && out_free;
  assign div_start = b_valid && b_item.last;

  vfsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (b_item.sum),
    .divisor  (b_item.total),
    .done     (div_done),
    .mean     (div_mean)
  );

  // Count memory write
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
  end

  // Count memory read; forward a same-cycle write, unwritten entries read zero
  always_ff @(posedge clk) begin
    if (cnt_re) begin
      if (cnt_we && (cnt_wa == cnt_ra)) begin
        cnt_rd <= cnt_wd;
      end else if (cnt_vld[cnt_ra]) begin
        cnt_rd <= cnt_mem[cnt_ra];
      end else begin
        cnt_rd <= '0;
      end
    end
  end

  // Order memory write and read
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[distinct_total[CNT_AW-1:0]] <= b_item.value;
    end
    if (ord_re) begin
      ord_rd <= ord_mem[walk[CNT_AW-1:0]];
    end
  end

  // Advance the popped item into the update stage
  always_ff @(posedge clk) begin
    if (pop) begin
      b_item <= queue_item;
    end
  end

  // Capture the batch totals with the marked item
  always_ff @(posedge clk) begin
    if (div_start) begin
      sum_hold  <= b_item.sum;
      drop_hold <= b_item.drop;
    end
  end

  // Sequence loading, walking and summary; clear the store at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      b_valid        <= 1'b0;
      cnt_vld        <= '0;
      distinct_total <= '0;
      walk           <= '0;
    end else begin
      b_valid <= pop;
      if (cnt_we) begin
        cnt_vld[cnt_wa] <= 1'b1;
      end
      if (ord_we) begin
        distinct_total <= distinct_total + 1'b1;
      end
      case (state)
        S_LOAD: begin
          if (div_start) begin
            walk  <= '0;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          state <= ord_re ? S_CNT : S_SUM;
        end
        S_CNT: begin
          state <= S_ENT;
        end
        S_ENT: begin
          if (load_ent) begin
            walk  <= walk + 1'b1;
            state <= S_NEXT;
          end
        end
        S_SUM: begin
          if (load_sum) begin
            cnt_vld        <= '0;
            distinct_total <= '0;
            state          <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ent || load_sum) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ent) begin
      out_result.kind         <= KIND_ENTRY;
      out_result.value        <= ord_rd;
      out_result.occurrences  <= cnt_rd;
      out_result.total_sum    <= '0;
      out_result.mean_rounded <= '0;
      out_result.overflowed   <= 1'b0;
      out_result.last_result  <= 1'b0;
    end else if (load_sum) begin
      out_result.kind         <= KIND_SUMMARY;
      out_result.value        <= '0;
      out_result.occurrences  <= '0;
      out_result.total_sum    <= sum_hold;
      out_result.mean_rounded <= div_mean;
      out_result.overflowed   <= drop_hold;
      out_result.last_result  <= 1'b1;
    end
  end

  // Checks
  a_pop_only_loading: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_LOAD))
    else $error("item popped outside loading");

  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    distinct_total <= (CNT_AW+1)'(CNT_D))
    else $error("distinct count beyond store depth");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (cnt_wd != '0))
    else $error("count wrapped to zero");

  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    load_sum |=> (distinct_total == '0) && (cnt_vld == '0))
    else $error("store not cleared after summary");

endmodule

`default_nettype wire

// File: hw/rtl/value_frequency_sum_average_top.sv
// ----------------------------------------------------------------------------
// value_frequency_sum_average_top: histogram with sum and rounded mean
// Counts a batch of small values, then reports each distinct value with its
// count in order of first appearance, followed by a sum and mean summary.
// ----------------------------------------------------------------------------
//
//   channel   dir   width               contents
//   s_*       in    tdata 8, tlast      sample value; tlast marks batch end
//   m_*       out   tdata 32, tuser 1   entry or summary; tlast on summary
//
// Loading takes one item per cycle: the count memory is read as an item
// leaves the queue and written the next cycle, with a bypass for repeats.
// On the marked item each distinct value passes through an order read, a count
// read and an output step, and the summary waits for the mean divider.
// The store is cleared in the summary cycle; no clearing pass after reset.
// Reset clears all control state. Either side may stall; the four-entry
// queue keeps accepting until full while results wait in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module value_frequency_sum_average_top #(
  parameter int BINS      = 32,
  parameter int MAX_ITEMS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] sample_value, [7:5] zero
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] value, [12:5] occurrences, [24:13] total_sum,
                                 // [29:25] mean_rounded, [30] overflowed, [31] zero
  output logic        m_tuser,   // result_kind
  output logic        m_tlast    // last_result
);
  import vfsa_pkg::*;

  logic         push;
  vfsa_item_t   push_item;
  logic         queue_full;
  logic         pop;
  vfsa_item_t   pop_item;
  logic         queue_empty;
  vfsa_result_t result;

  vfsa_front #(
    .BINS      (BINS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .in_last    (s_tlast),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  vfsa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  vfsa_back #(
    .BINS (BINS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_item  (pop_item),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (result)
  );

  // Pack the result onto the stream
  assign m_tdata = {1'b0, result.overflowed, result.mean_rounded, result.total_sum,
                    result.occurrences, result.value};
  assign m_tuser = result.kind;
  assign m_tlast = result.last_result;

endmodule

`default_nettype wire

// File: verif/value_frequency_sum_average_top_tb.sv
// ----------------------------------------------------------------------------
// value_frequency_sum_average_top_tb: self-checking bench for the histogram
// Streams batches of 5-bit samples into the block and tracks every batch with
// a local histogram, first-seen order and rounded mean. Each output transfer
// is checked field by field against the oldest expected result. Covers rounding
// ties, repeated values, all 32 values in one batch and the item-limit drop.
// Random stalls hit both sides until the last stretch of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module value_frequency_sum_average_top_tb;
  import vfsa_pkg::*;

  localparam int BINS         = 32;
  localparam int MAX_ITEMS    = 128;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int CALM_TAIL    = 30;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               fin;
    logic               drain;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [4:0] sample_value, [7:5] zero
  logic        s_tlast = 1'b0;   // last_item
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [4:0] value, [12:5] occurrences, [24:13] total_sum,
                                 // [29:25] mean_rounded, [30] overflowed, [31] zero
  logic        m_tuser;          // result_kind
  logic        m_tlast;          // last_result

  value_frequency_sum_average_top #(
    .BINS      (BINS),
    .MAX_ITEMS (MAX_ITEMS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Stimulus and expected results
  sample_t      sample_q[$];
  vfsa_result_t due_results[$];

  // Local copy of the batch tally
  logic [COUNT_W-1:0] hist [BINS];
  logic [VALUE_W-1:0] seen_order [BINS];
  int unsigned        n_distinct;
  logic [SUM_W-1:0]   acc_sum;
  int unsigned        n_counted;
  logic               dropped;

  int issued_cnt   = 0;
  int taken_cnt    = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int batches_seen = 0;
  int cycles       = 0;

  task automatic clear_tally();
    for (int i = 0; i < BINS; i++) begin
      hist[i]       = '0;
      seen_order[i] = '0;
    end
    n_distinct = 0;
    acc_sum    = '0;
    n_counted  = 0;
    dropped    = 1'b0;
  endtask

  // Fold one sample into the tally; on the batch end queue its results
  task automatic absorb_sample(input logic [VALUE_W-1:0] v, input logic fin);
    vfsa_result_t r;
    int unsigned  wide_sum;
    int unsigned  q;
    int unsigned  rem;
    if (v < BINS) begin
      if (n_counted >= MAX_ITEMS) begin
        dropped = 1'b1;
      end else begin
        if (hist[v] == 0 && n_distinct < BINS) begin
          seen_order[n_distinct] = v;
          n_distinct++;
        end
        hist[v]  = hist[v] + 1'b1;
        wide_sum = acc_sum + v;
        acc_sum  = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
        n_counted++;
      end
    end
    if (fin) begin
      for (int k = 0; k < n_distinct && k < BINS; k++) begin
        r             = '0;
        r.kind        = KIND_ENTRY;
        r.value       = seen_order[k];
        r.occurrences = hist[seen_order[k]];
        due_results.push_back(r);
      end
      // Round to nearest, ties to even
      q = 0;
      if (n_counted != 0) begin
        q   = acc_sum / n_counted;
        rem = acc_sum % n_counted;
        if (2 * rem > n_counted || (2 * rem == n_counted && q[0]))
          q++;
      end
      r              = '0;
      r.kind         = KIND_SUMMARY;
      r.total_sum    = acc_sum;
      r.mean_rounded = q[MEAN_W-1:0];
      r.overflowed   = dropped;
      r.last_result  = 1'b1;
      due_results.push_back(r);
      clear_tally();
    end
  endtask

  function automatic string fmt_result(input vfsa_result_t r);
    return $sformatf("kind=%0d value=%0d occ=%0d sum=%0d mean=%0d ovf=%0d last=%0d",
                     r.kind, r.value, r.occurrences, r.total_sum, r.mean_rounded,
                     r.overflowed, r.last_result);
  endfunction

  task automatic note_mismatch(input string what, input string want, input string got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch #%0d at cycle %0d: %s\n  expected: %s\n  actual:   %s",
               mismatches, cycles, what, want, got);
  endtask

  task automatic add_sample(input int v, input bit fin, input bit drain);
    sample_t s;
    s.val   = v[VALUE_W-1:0];
    s.fin   = fin;
    s.drain = drain;
    sample_q.push_back(s);
  endtask

  // Short batches; a third of them use a narrow value window for repeats
  task automatic add_random_batches(input int n_items);
    int left;
    int len;
    int span;
    int base;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left)
        len = left;
      span = ($urandom_range(0, 2) == 0) ? 3 : 31;
      base = $urandom_range(0, 31 - span);
      for (int i = 0; i < len; i++)
        add_sample(base + $urandom_range(0, span), i == len - 1, 1'b0);
      left -= len;
    end
  endtask

  // Monitor: capture input transfers and check output transfers
  always @(posedge clk) begin
    vfsa_result_t got;
    vfsa_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        absorb_sample(s_tdata[VALUE_W-1:0], s_tlast);
        taken_cnt++;
      end
      if (m_tvalid && m_tready) begin
        got.kind         = m_tuser;
        got.value        = m_tdata[4:0];
        got.occurrences  = m_tdata[12:5];
        got.total_sum    = m_tdata[24:13];
        got.mean_rounded = m_tdata[29:25];
        got.overflowed   = m_tdata[30];
        got.last_result  = m_tlast;
        results_seen++;
        if (m_tlast)
          batches_seen++;
        if (due_results.size() == 0) begin
          note_mismatch("result with none expected", "-", fmt_result(got));
        end else begin
          want = due_results.pop_front();
          if (got.kind != want.kind || got.value != want.value ||
              got.occurrences != want.occurrences || got.total_sum != want.total_sum ||
              got.mean_rounded != want.mean_rounded || got.overflowed != want.overflowed ||
              got.last_result != want.last_result)
            note_mismatch("field mismatch", fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  // Driver: present samples and toggle the output ready at the falling edge
  always @(negedge clk) begin
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      // Hold the current transfer until it is taken
      if (!(s_tvalid && taken_cnt != issued_cnt)) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() == 0 ||
                     (sample_q[0].drain && due_results.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else if (sample_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 14);
          s_tvalid <= 1'b0;
        end else begin
          nxt = sample_q.pop_front();
          s_tdata  <= {3'b000, nxt.val};
          s_tlast  <= nxt.fin;
          s_tvalid <= 1'b1;
          issued_cnt++;
        end
      end
      // Stall the result side in bursts
      if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else if (sample_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int perm [BINS];
    int j;
    int t;
    clear_tally();

    // Directed: extremes, rounding ties both ways, repeats
    add_sample(0, 1, 0);
    add_sample(31, 1, 0);
    add_sample(1, 0, 0);  add_sample(2, 1, 0);                        // tie, rounds up to even
    add_sample(1, 0, 0);  add_sample(4, 1, 0);                        // tie, stays even
    add_sample(0, 0, 0);  add_sample(0, 0, 0);  add_sample(1, 1, 0);  // rounds down
    add_sample(0, 0, 0);  add_sample(1, 0, 0);  add_sample(1, 1, 0);  // rounds up
    add_sample(5, 0, 0);  add_sample(5, 0, 0);  add_sample(7, 0, 0);
    add_sample(5, 0, 0);  add_sample(7, 0, 0);  add_sample(3, 1, 0);

    // Every value once, shuffled; wait for all results before starting it
    for (int i = 0; i < BINS; i++)
      perm[i] = i;
    for (int i = BINS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < BINS; i++)
      add_sample(perm[i], i == BINS - 1, i == 0);

    add_random_batches(10);

    // Full batch of the top value, then extras that must be dropped
    for (int i = 0; i < MAX_ITEMS; i++)
      add_sample(31, 0, 0);
    for (int i = 0; i < 4; i++)
      add_sample($urandom_range(0, 31), i == 3, 0);

    add_random_batches(20);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || taken_cnt != issued_cnt)
      @(posedge clk);
    while (due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += due_results.size();

    $display("Sent %0d samples; checked %0d results across %0d batches.",
             taken_cnt, results_seen, batches_seen);
    $display("Included rounding ties, repeats, all values in one batch and item-limit drops.");
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
